[rtl/mpk_pkg.sv]
// ----------------------------------------------------------------------------
// mpk_pkg: shared types and constants
// Command/status structs between controller and datapath, register indexes,
// reset values and operand codes for the escape-time kernel.
// ----------------------------------------------------------------------------
`default_nettype none
package mpk_pkg;

  localparam int ITER_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 28;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [15:0] ITER_LIMIT_RST = 16'd6000;
  localparam logic [23:0] ESC_BOUND_RST  = 24'd10000000;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_BOUND  = 8'd1;

  // product being formed on the shared multiplier
  localparam logic [1:0] OP_XX = 2'd0;
  localparam logic [1:0] OP_YY = 2'd1;
  localparam logic [1:0] OP_XY = 2'd2;

  typedef struct packed {
    logic       load;       // take c, clear z and count
    logic       issue;      // issue one partial product
    logic [1:0] kidx;       // partial product index {a half, b half}
    logic [1:0] op;         // operand selection
    logic       latch;      // store finished product for op
    logic       mlatch;     // store |z|^2 for the log unit
    logic       update;     // advance z and count
    logic       log_start;  // start the log unit
    logic       out_load;   // load the output register
    logic       out_inside; // result is an inside point
  } cmd_t;

  typedef struct packed {
    logic esc;       // |z|^2 reached the bound
    logic lim;       // count reached the limit
    logic log_done;  // log result ready
    logic out_free;  // output register can take a result
  } stat_t;

endpackage
`default_nettype wire

[rtl/mandelbrot_potential_kernel.sv]
// ----------------------------------------------------------------------------
// mandelbrot_potential_kernel: escape-time kernel with potential output
// Iterates z = z*z + c for one point and reports count, inside flag and
// half the natural log of |z|^2 at escape.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one point c per transfer (Q3.28 real and imaginary parts).
//   m_axis returns one result per point: iteration count and 0.5*ln(|z|^2)
//   in Q8.16 in tdata, the inside flag in tuser.
//   cfg writes iteration_limit (index 0) and escape_bound_sq (index 1); it is
//   always ready and should be used only while no point is in flight.
// Sequence:
//   Each z step forms three wide products, each as four partial
//   products on one shared half-width multiplier plus drain and
//   store; the escape and limit check comes after x*x and y*y, and the
//   z update after x*y. An escaped point then runs the log unit
//   (bit-serial normalize, 24 squaring steps) before its result is valid.
//   Points are handled one at a time; s_axis_tready is high only while idle.
// Reset: rst clears the sequencer, the output valid and loads the register
//   defaults (limit 6000, bound 10000000).
// Stall: a finished result waits in the output register; the next point is
//   accepted and iterated meanwhile and its result holds until the register
//   is free.
// ----------------------------------------------------------------------------
`default_nettype none
module mandelbrot_potential_kernel #(
  parameter int ITER_WIDTH = mpk_pkg::ITER_WIDTH_DEF,
  parameter int FRAC_BITS  = mpk_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [63:0]                   s_axis_tdata,  // c_real, c_imag
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [39:0]                        m_axis_tdata,  // iterations, half_log_mag
  output logic                               m_axis_tuser,  // inside_res
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mpk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);
  import mpk_pkg::*;

  cmd_t        cmd;
  stat_t       st;
  logic [63:0] mag_sq;
  logic        log_done;
  logic [23:0] log_result;
  logic [15:0] out_iter;
  logic [23:0] out_half;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  mpk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  mpk_dp #(
    .ITER_WIDTH (ITER_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_data    (s_axis_tdata),
    .cfg_we     (cfg_valid),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .mag_sq     (mag_sq),
    .log_done   (log_done),
    .log_result (log_result),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_iter   (out_iter),
    .out_inside (m_axis_tuser),
    .out_half   (out_half)
  );

  // log unit runs once per escaped point
  mpk_log #(
    .FRAC_BITS (FRAC_BITS)
  ) u_log (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.log_start),
    .mag    (mag_sq),
    .done   (log_done),
    .result (log_result)
  );

  assign m_axis_tdata = {out_half, out_iter};

endmodule
`default_nettype wire

[rtl/mpk_log.sv]
// ----------------------------------------------------------------------------
// mpk_log: iterative half natural log
// Normalizes one bit a cycle, then 24 squaring steps on a 32-bit mantissa,
// then scales log2 by ln2/2 into unsigned Q8.16.
// ----------------------------------------------------------------------------
`default_nettype none
module mpk_log #(
  parameter int FRAC_BITS = mpk_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] mag,
  output logic             done,
  output logic [23:0]      result
);
  import mpk_pkg::*;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_NORM = 3'd1;
  localparam logic [2:0] L_MUL  = 3'd2;
  localparam logic [2:0] L_STEP = 3'd3;
  localparam logic [2:0] L_PROD = 3'd4;
  localparam logic [2:0] L_OUT  = 3'd5;

  localparam logic [5:0] FB = 6'(FRAC_BITS);

  logic [2:0]  state;
  logic [63:0] norm;
  logic [5:0]  p;
  logic [31:0] mant;
  logic [63:0] sq;
  logic [23:0] frac;
  logic [4:0]  step;
  logic [61:0] prod;
  logic [32:0] t;
  logic        pos;
  logic [29:0] lv;

  assign t   = sq[63:31];
  assign pos = (p > FB) || ((p == FB) && (frac != 24'd0));
  assign lv  = {p - FB, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            norm  <= mag;
            p     <= 6'd63;
            frac  <= 24'd0;
            step  <= 5'd0;
            state <= (mag == 64'd0) ? L_OUT : L_NORM;
            prod  <= 62'd0;
          end
        end
        L_NORM: begin
          if (norm[63]) begin
            mant  <= norm[63:32];
            state <= L_MUL;
          end else begin
            norm <= {norm[62:0], 1'b0};
            p    <= p - 6'd1;
          end
        end
        L_MUL: begin
          sq    <= 64'(mant) * 64'(mant);
          state <= L_STEP;
        end
        L_STEP: begin
          frac <= {frac[22:0], t[32]};
          mant <= t[32] ? t[32:1] : t[31:0];
          step <= step + 5'd1;
          state <= (step == 5'd23) ? L_PROD : L_MUL;
        end
        L_PROD: begin
          prod  <= pos ? 62'(lv) * 62'(LN2_Q32) : 62'd0;
          state <= L_OUT;
        end
        L_OUT: begin
          result <= 24'(prod >> 41);
          done   <= 1'b1;
          state  <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/mpk_ctrl.sv]
// ----------------------------------------------------------------------------
// mpk_ctrl: iteration sequencer
// Steps the shared multiplier through the three products of each iteration,
// checks for escape and limit, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module mpk_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mpk_pkg::stat_t st,
  output mpk_pkg::cmd_t      cmd
);
  import mpk_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_LATCH = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_UPD   = 4'd5;
  localparam logic [3:0] S_LOGS  = 4'd6;
  localparam logic [3:0] S_LOGW  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state;
  logic [1:0] k;
  logic [1:0] op;
  logic       lim_hit;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == S_IDLE) && in_valid;
    cmd.issue      = (state == S_MUL);
    cmd.kidx       = k;
    cmd.op         = op;
    cmd.latch      = (state == S_LATCH);
    cmd.mlatch     = (state == S_CHECK);
    cmd.update     = (state == S_UPD);
    cmd.log_start  = (state == S_LOGS);
    cmd.out_load   = (state == S_OUT) && st.out_free;
    cmd.out_inside = lim_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      k       <= 2'd0;
      op      <= OP_XX;
      lim_hit <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= OP_XX;
            k     <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          k <= k + 2'd1;
          if (k == 2'd3) state <= S_DRAIN;
        end
        S_DRAIN: state <= S_LATCH;
        S_LATCH: begin
          priority if (op == OP_XX) begin
            op    <= OP_YY;
            state <= S_MUL;
          end else if (op == OP_YY) begin
            state <= S_CHECK;
          end else begin
            state <= S_UPD;
          end
        end
        S_CHECK: begin
          lim_hit <= st.lim;
          priority if (st.lim) begin
            state <= S_OUT;
          end else if (st.esc) begin
            state <= S_LOGS;
          end else begin
            op    <= OP_XY;
            state <= S_MUL;
          end
        end
        S_UPD: begin
          op    <= OP_XX;
          state <= S_MUL;
        end
        S_LOGS: state <= S_LOGW;
        S_LOGW: if (st.log_done) state <= S_OUT;
        S_OUT:  if (st.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/mpk_dp.sv]
// ----------------------------------------------------------------------------
// mpk_dp: iteration datapath
// Holds c, z, count and the config registers; forms the wide products on one
// half-width multiplier with a registered accumulate; holds the result.
// ----------------------------------------------------------------------------
`default_nettype none
module mpk_dp #(
  parameter int ITER_WIDTH = mpk_pkg::ITER_WIDTH_DEF,
  parameter int FRAC_BITS  = mpk_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire mpk_pkg::cmd_t                   cmd,
  output mpk_pkg::stat_t                       st,
  input  wire logic [63:0]                     in_data,
  input  wire logic                            cfg_we,
  input  wire logic [mpk_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [31:0]                     cfg_wdata,
  output logic [63:0]                          mag_sq,
  input  wire logic                            log_done,
  input  wire logic [23:0]                     log_result,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [15:0]                          out_iter,
  output logic                                 out_inside,
  output logic [23:0]                          out_half
);
  import mpk_pkg::*;

  localparam int ZM_W = (FRAC_BITS + 27 >= 63) ? 63 : FRAC_BITS + 27;
  localparam int H    = (ZM_W + 1) / 2;
  localparam int AW   = 4 * H;
  localparam logic [32:0] ONE_SH   = 33'd1 << ITER_WIDTH;
  localparam logic [31:0] LIM_MASK = 32'(ONE_SH - 33'd1);

  logic [15:0] iter_limit;
  logic [23:0] esc_bound;
  logic [31:0] cr, ci;
  logic [ZM_W-1:0] zx_mag, zy_mag;
  logic            zx_neg, zy_neg;
  logic [ITER_WIDTH-1:0] count;
  logic [63:0] sx, sy;
  logic [ZM_W-1:0] cmag;
  logic            cneg;

  logic [2*H-1:0] preg;
  logic [1:0]     pidx;
  logic           pvalid, pfirst;
  logic [AW-1:0]  acc;

  // clamp a signed sum to +-zmax, returned as {neg, magnitude}
  function automatic logic [ZM_W:0] clamp(input logic signed [65:0] s);
    logic [65:0] m;
    logic        n;
    n = s[65];
    m = n ? 66'(-s) : 66'(s);
    if ((m >> ZM_W) != 66'd0) return {n, {ZM_W{1'b1}}};
    return {n, m[ZM_W-1:0]};
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      iter_limit <= ITER_LIMIT_RST;
      esc_bound  <= ESC_BOUND_RST;
    end else if (cfg_we) begin
      if (cfg_idx == REG_ITER_LIMIT) iter_limit <= cfg_wdata[15:0];
      if (cfg_idx == REG_ESC_BOUND)  esc_bound  <= cfg_wdata[23:0];
    end
  end

  // operand halves for the shared multiplier
  logic [ZM_W-1:0] opa, opb;
  logic [H-1:0]    ha, hb;
  always_comb begin
    opa = (cmd.op == OP_YY) ? zy_mag : zx_mag;
    opb = (cmd.op == OP_XX) ? zx_mag : zy_mag;
    ha  = cmd.kidx[1] ? H'(opa >> H) : opa[H-1:0];
    hb  = cmd.kidx[0] ? H'(opb >> H) : opb[H-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
    end else begin
      pvalid <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      preg   <= (2*H)'(ha) * (2*H)'(hb);
      pidx   <= 2'(cmd.kidx[1]) + 2'(cmd.kidx[0]);
      pfirst <= (cmd.kidx == 2'd0);
    end
    if (pvalid) begin
      unique case (pidx)
        2'd0:    acc <= (pfirst ? '0 : acc) + AW'(preg);
        2'd1:    acc <= acc + (AW'(preg) << H);
        default: acc <= acc + (AW'(preg) << (2*H));
      endcase
    end
  end

  // finished product views
  logic [AW-1:0] qsq, qcr;
  logic [63:0]   sqv;
  logic [ZM_W-1:0] crv;
  always_comb begin
    qsq = acc >> FRAC_BITS;
    qcr = acc >> (FRAC_BITS - 1);
    sqv = ((qsq >> 64) != '0) ? {64{1'b1}} : qsq[63:0];
    crv = ((qcr >> ZM_W) != '0) ? {ZM_W{1'b1}} : qcr[ZM_W-1:0];
  end

  // |z|^2, escape and limit
  logic [64:0] msum;
  logic [63:0] m_now;
  logic [31:0] count_ext, lim;
  always_comb begin
    msum      = 65'(sx) + 65'(sy);
    m_now     = msum[64] ? {64{1'b1}} : msum[63:0];
    count_ext = 32'(count);
    lim       = 32'(iter_limit) & LIM_MASK;
    st.esc      = (m_now >> FRAC_BITS) >= 64'(esc_bound);
    st.lim      = count_ext >= lim;
    st.log_done = log_done;
    st.out_free = !out_valid || out_ready;
  end

  // next z
  logic [63:0] diff;
  logic [ZM_W-1:0] dmag;
  logic signed [65:0] dval, cval, sxn, syn;
  logic [ZM_W:0] zxc, zyc;
  always_comb begin
    diff = (sx >= sy) ? sx - sy : sy - sx;
    dmag = ((diff >> ZM_W) != 64'd0) ? {ZM_W{1'b1}} : diff[ZM_W-1:0];
    dval = (sx < sy) ? -$signed(66'(dmag)) : $signed(66'(dmag));
    cval = cneg ? -$signed(66'(cmag)) : $signed(66'(cmag));
    sxn  = dval + $signed({{34{cr[31]}}, cr});
    syn  = cval + $signed({{34{ci[31]}}, ci});
    zxc  = clamp(sxn);
    zyc  = clamp(syn);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr     <= in_data[31:0];
      ci     <= in_data[63:32];
      zx_mag <= '0;
      zy_mag <= '0;
      zx_neg <= 1'b0;
      zy_neg <= 1'b0;
      count  <= '0;
    end
    if (cmd.latch) begin
      unique case (cmd.op)
        OP_XX: sx <= sqv;
        OP_YY: sy <= sqv;
        default: begin
          cmag <= crv;
          cneg <= zx_neg ^ zy_neg;
        end
      endcase
    end
    if (cmd.mlatch) mag_sq <= m_now;
    if (cmd.update) begin
      zx_neg <= zxc[ZM_W];
      zx_mag <= zxc[ZM_W-1:0];
      zy_neg <= zyc[ZM_W];
      zy_mag <= zyc[ZM_W-1:0];
      count  <= count + ITER_WIDTH'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_iter   <= count_ext[15:0];
      out_inside <= cmd.out_inside;
      out_half   <= cmd.out_inside ? 24'd0 : log_result;
    end
  end

endmodule
`default_nettype wire
